/* sv/fhn_pkg.sv */
// Shared constants, types and helper functions for the FHN cell engine.
package fhn_pkg;

    localparam int GRID_SIDE  = 128;
    localparam int CELLS      = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int COORD_W    = 7;
    localparam int COORD_MAX  = GRID_SIDE - 1;

    localparam int SIG_DEPTH  = 256;
    localparam int SIG_AW     = $clog2(SIG_DEPTH);
    localparam int SIG_STEP   = 8192 / SIG_DEPTH;

    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 26;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int RQ_W       = PROD_W - 12;
    localparam int LAP_W      = 19;

    localparam logic signed [15:0] V_INIT = -16'sd4246;
    localparam logic signed [15:0] W_INIT = -16'sd2726;

    localparam int EPS_Q       = 1802;
    localparam int WL_Q        = 1638;
    localparam int BETA_Q      = 2867;
    localparam int IPACE_Q     = 8192;
    localparam int THRESH_Q    = 1024;
    localparam int PACE_R2     = 16;
    localparam int PACE_RADIUS = 4;

    // v^3/3 rounding: bias for the 2^24 step, then floor divide by 3
    localparam int CUBE_BIAS   = 25165824;
    localparam int DIV3_OFF    = 12582912;
    localparam int DIV3_BASE   = 4194304;
    localparam int RECIP3      = 22369622;
    // divide by eps: offset keeps the dividend positive
    localparam int EPS_OFF     = 1845248;
    localparam int EPS_Q_BASE  = 1024;
    localparam int RECIP_EPS_A = 4766890;
    localparam int RECIP_EPS_B = 9533779;

    localparam logic [1:0] CMD_COMPUTE = 2'd0;
    localparam logic [1:0] CMD_COMMIT  = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    localparam logic [2:0] REG_TIME_STEP    = 3'd0;
    localparam logic [2:0] REG_DIFF_GAIN    = 3'd1;
    localparam logic [2:0] REG_REC_HIGH     = 3'd2;
    localparam logic [2:0] REG_PACER_REC_LO = 3'd3;
    localparam logic [2:0] REG_PACER_ON     = 3'd4;
    localparam logic [2:0] REG_PACER_OFF    = 3'd5;
    localparam logic [2:0] REG_BEAT_LIMIT   = 3'd6;
    localparam logic [2:0] REG_PACER_CENTER = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic               we_cur;
        logic               we_nxt;
        logic signed [15:0] wv;
        logic signed [15:0] ww;
    } t_grid_req;

    typedef struct packed {
        logic signed [15:0] v;
        logic signed [15:0] w;
        logic signed [15:0] nv;
        logic signed [15:0] nw;
    } t_grid_rd;

    typedef logic [SIG_DEPTH-1:0][12:0] t_sig_table;

    // Logistic table built at elaboration: exp by squaring constants, round-divide by long division
    function automatic t_sig_table build_sig();
        logic [63:0] c [16];
        t_sig_table  tab;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] a;
        int          vc;
        int          z;
        c[0] = 64'd4293918848;
        for (int k = 1; k < 16; k++) begin
            c[k] = (c[k-1] * c[k-1] + 64'h8000_0000) >> 32;
        end
        for (int i = 0; i < SIG_DEPTH; i++) begin
            vc = -8192 + (2 * i + 1) * SIG_STEP;
            z  = -4 * vc;
            a  = 64'(z < 0 ? -z : z);
            p  = 64'h1_0000_0000;
            for (int k = 0; k < 16; k++) begin
                if (a[k]) begin
                    p = (p * c[k] + 64'h8000_0000) >> 32;
                end
            end
            if ((a >> 16) != 64'd0) begin
                p = 64'd0;
            end
            den = 64'h1_0000_0000 + p;
            num = (64'd1 << 44) + (den >> 1);
            rem = 64'd0;
            q   = 64'd0;
            for (int b = 45; b >= 0; b--) begin
                rem = (rem << 1) | 64'(num[b]);
                if (rem >= den) begin
                    rem  = rem - den;
                    q[b] = 1'b1;
                end
            end
            tab[i] = (z >= 0) ? 13'(q) : 13'(64'd4096 - q);
        end
        return tab;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig();

    function automatic logic signed [RQ_W-1:0] rq(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + PROD_W'(2048);
        return RQ_W'(t >>> 12);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
        logic signed [15:0] r;
        if (x > 48'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -48'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(x);
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] r;
        if (int'(c) > COORD_MAX) begin
            r = COORD_W'(COORD_MAX);
        end else begin
            r = c;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] c,
                                                   input logic [COORD_W-1:0] r);
        return ADDR_W'(int'(c) * GRID_SIDE + int'(r));
    endfunction

endpackage

/* sv/fhn_mul.sv */
// Shared signed multiplier with registered product.
module fhn_mul (
    input  logic                               i_clk,
    input  logic signed [fhn_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [fhn_pkg::MUL_B_W-1:0] i_b,
    output logic signed [fhn_pkg::PROD_W-1:0]  o_prod
);
    import fhn_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* sv/fhn_grid.sv */
// Grid storage: current and next v/w memories with a clearing pass after reset.
module fhn_grid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fhn_pkg::t_grid_req i_req,
    output fhn_pkg::t_grid_rd  o_rd,
    output logic               o_ready
);
    import fhn_pkg::*;

    logic [15:0] mem_v  [CELLS];
    logic [15:0] mem_w  [CELLS];
    logic [15:0] mem_nv [CELLS];
    logic [15:0] mem_nw [CELLS];

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    t_grid_rd          r_rd;

    logic [ADDR_W-1:0] addr;
    logic              we_cur;
    logic              we_nxt;
    logic [15:0]       dv;
    logic [15:0]       dw;
    logic [15:0]       dnv;
    logic [15:0]       dnw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // sweep the reset values in while clearing
    always_comb begin
        addr   = r_clr_busy ? r_clr_addr : i_req.addr;
        we_cur = r_clr_busy | i_req.we_cur;
        we_nxt = r_clr_busy | i_req.we_nxt;
        dv     = r_clr_busy ? V_INIT : i_req.wv;
        dw     = r_clr_busy ? W_INIT : i_req.ww;
        dnv    = r_clr_busy ? 16'd0  : i_req.wv;
        dnw    = r_clr_busy ? 16'd0  : i_req.ww;
    end

    always_ff @(posedge i_clk) begin
        if (we_cur) begin
            mem_v[addr] <= dv;
            mem_w[addr] <= dw;
        end
        if (we_nxt) begin
            mem_nv[addr] <= dnv;
            mem_nw[addr] <= dnw;
        end
        r_rd.v  <= mem_v[addr];
        r_rd.w  <= mem_w[addr];
        r_rd.nv <= mem_nv[addr];
        r_rd.nw <= mem_nw[addr];
    end

    assign o_rd    = r_rd;
    assign o_ready = !r_clr_busy;

endmodule

/* sv/fhn_reaction_diffusion_cell_unit.sv */
// Top level: FHN reaction-diffusion cell engine with a sequencer around one shared multiplier.
//
//   channel   signals                                   handshake
//   command   start, busy, i_command, i_col, i_row      transfer when start & !busy
//   result    o_valid, o_video_sample .. o_stop_step    one-cycle strobe, no back-pressure
//   config    i_cfg_we, i_cfg_idx, i_cfg_data           write when i_cfg_we
//
// A compute reads the grid five times over the single memory port, overlapping the cube and
// the divide by eps, with eleven passes through the shared multiplier in all. A commit reads
// the next values and writes them to the current memories; an advance only steps the counter.
// After reset the grid clearing pass holds busy high until every cell has been cleared.
// Results come out for exactly one cycle; the receiver cannot stall them.
module fhn_reaction_diffusion_cell_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [6:0]         i_col,
    input  logic [6:0]         i_row,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [19:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_video_sample,
    output logic signed [15:0] o_next_potential,
    output logic signed [15:0] o_next_recovery,
    output logic               o_beat_counted,
    output logic               o_pacer_stop_event,
    output logic [19:0]        o_stop_step
);
    import fhn_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_CMT_RD = 5'd1;
    localparam logic [4:0] ST_CMT_WR = 5'd2;
    localparam logic [4:0] ST_RD0    = 5'd3;
    localparam logic [4:0] ST_RD1    = 5'd4;
    localparam logic [4:0] ST_RD2    = 5'd5;
    localparam logic [4:0] ST_RD3    = 5'd6;
    localparam logic [4:0] ST_RD4    = 5'd7;
    localparam logic [4:0] ST_RD5    = 5'd8;
    localparam logic [4:0] ST_D1     = 5'd9;
    localparam logic [4:0] ST_D2     = 5'd10;
    localparam logic [4:0] ST_D3     = 5'd11;
    localparam logic [4:0] ST_D4     = 5'd12;
    localparam logic [4:0] ST_D5     = 5'd13;
    localparam logic [4:0] ST_D6     = 5'd14;
    localparam logic [4:0] ST_D7     = 5'd15;
    localparam logic [4:0] ST_D8     = 5'd16;

    // configuration
    logic [14:0]        r_dt;
    logic [14:0]        r_gain;
    logic signed [15:0] r_wh;
    logic signed [15:0] r_wl_pace;
    logic [19:0]        r_on;
    logic [19:0]        r_off;
    logic [15:0]        r_limit;
    logic [13:0]        r_center;

    // control state
    logic [4:0]  r_state, n_state;
    logic [19:0] r_step, n_step;
    logic [15:0] r_beats, n_beats;
    logic        r_stop_rec, n_stop_rec;
    logic [19:0] r_held, n_held;
    logic        r_valid, n_valid;

    // datapath
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic signed [15:0] r_v, n_v;
    logic signed [15:0] r_w, n_w;
    logic signed [LAP_W-1:0] r_lap, n_lap;
    logic signed [15:0] r_wl, n_wl;
    logic               r_ip, n_ip;
    logic               r_stop_ev, n_stop_ev;
    logic [21:0]        r_np, n_np;
    logic [11:0]        r_qnp, n_qnp;
    logic [12:0]        r_sig, n_sig;
    logic signed [17:0] r_g, n_g;
    logic signed [26:0] r_acc, n_acc;
    logic signed [15:0] r_vt, n_vt;
    logic [14:0]        r_a, n_a;
    logic signed [15:0] r_out_vs, n_out_vs;
    logic signed [15:0] r_out_nv, n_out_nv;
    logic signed [15:0] r_out_nw, n_out_nw;
    logic               r_out_beat, n_out_beat;

    t_grid_req grid_req;
    t_grid_rd  grid_rd;
    logic      grid_ready;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [RQ_W-1:0]    rq_p;

    logic                      accept;
    logic [COORD_W-1:0]        cin, rin, cm, cp, rm, rp;
    logic [6:0]                cc, cr;
    logic signed [7:0]         dcol, drow;
    logic [7:0]                acol, arow;
    logic [5:0]                r2;
    logic                      in_zone;
    logic                      pace_on;
    logic signed [PROD_W-1:0]  t_cube;
    logic signed [25:0]        yp;
    logic signed [24:0]        c3;
    logic signed [25:0]        np;
    logic [22:0]               rn_full;
    logic [22:0]               m_op;
    logic signed [24:0]        react;
    logic signed [19:0]        sigma;
    logic signed [15:0]        wt;
    logic signed [16:0]        u_sig;
    logic [13:0]               u_cl;

    fhn_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (grid_req),
        .o_rd    (grid_rd),
        .o_ready (grid_ready)
    );

    fhn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    assign busy   = (r_state != ST_IDLE) || !grid_ready;
    assign accept = start && !busy;
    assign rq_p   = rq(mul_p);

    assign cin = clamp_coord(i_col);
    assign rin = clamp_coord(i_row);
    assign cm  = (r_col > '0) ? r_col - 1'b1 : r_col;
    assign cp  = (int'(r_col) < COORD_MAX) ? r_col + 1'b1 : r_col;
    assign rm  = (r_row > '0) ? r_row - 1'b1 : r_row;
    assign rp  = (int'(r_row) < COORD_MAX) ? r_row + 1'b1 : r_row;

    // pacemaker zone: both offsets within the radius, then the squared distance
    assign cc      = r_center[13:7];
    assign cr      = r_center[6:0];
    assign dcol    = $signed({1'b0, r_col}) - $signed({1'b0, cc});
    assign drow    = $signed({1'b0, r_row}) - $signed({1'b0, cr});
    assign acol    = dcol[7] ? 8'(-dcol) : 8'(dcol);
    assign arow    = drow[7] ? 8'(-drow) : 8'(drow);
    assign r2      = 6'(acol[2:0]) * 6'(acol[2:0]) + 6'(arow[2:0]) * 6'(arow[2:0]);
    assign in_zone = (int'(acol) <= PACE_RADIUS) && (int'(arow) <= PACE_RADIUS)
                     && (int'(r2) <= PACE_R2);
    assign pace_on = in_zone && (r_step > r_on);

    // sigmoid index from v
    assign u_sig = 17'(r_v) + 17'sd8192;
    assign u_cl  = u_sig[16] ? 14'd0 : ((u_sig > 17'sd16383) ? 14'd16383 : u_sig[13:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt      <= 15'd102;
            r_gain    <= 15'd1638;
            r_wh      <= 16'sd4096;
            r_wl_pace <= 16'sd410;
            r_on      <= 20'd0;
            r_off     <= 20'hfffff;
            r_limit   <= 16'hffff;
            r_center  <= 14'd5248;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TIME_STEP:    r_dt      <= i_cfg_data[14:0];
                REG_DIFF_GAIN:    r_gain    <= i_cfg_data[14:0];
                REG_REC_HIGH:     r_wh      <= i_cfg_data[15:0];
                REG_PACER_REC_LO: r_wl_pace <= i_cfg_data[15:0];
                REG_PACER_ON:     r_on      <= i_cfg_data;
                REG_PACER_OFF:    r_off     <= i_cfg_data;
                REG_BEAT_LIMIT:   r_limit   <= i_cfg_data[15:0];
                REG_PACER_CENTER: r_center  <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= '0;
            r_beats    <= '0;
            r_stop_rec <= 1'b0;
            r_held     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_beats    <= n_beats;
            r_stop_rec <= n_stop_rec;
            r_held     <= n_held;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_row      <= n_row;
        r_addr     <= n_addr;
        r_v        <= n_v;
        r_w        <= n_w;
        r_lap      <= n_lap;
        r_wl       <= n_wl;
        r_ip       <= n_ip;
        r_stop_ev  <= n_stop_ev;
        r_np       <= n_np;
        r_qnp      <= n_qnp;
        r_sig      <= n_sig;
        r_g        <= n_g;
        r_acc      <= n_acc;
        r_vt       <= n_vt;
        r_a        <= n_a;
        r_out_vs   <= n_out_vs;
        r_out_nv   <= n_out_nv;
        r_out_nw   <= n_out_nw;
        r_out_beat <= n_out_beat;
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_beats    = r_beats;
        n_stop_rec = r_stop_rec;
        n_held     = r_held;
        n_valid    = 1'b0;
        n_col      = r_col;
        n_row      = r_row;
        n_addr     = r_addr;
        n_v        = r_v;
        n_w        = r_w;
        n_lap      = r_lap;
        n_wl       = r_wl;
        n_ip       = r_ip;
        n_stop_ev  = r_stop_ev;
        n_np       = r_np;
        n_qnp      = r_qnp;
        n_sig      = r_sig;
        n_g        = r_g;
        n_acc      = r_acc;
        n_vt       = r_vt;
        n_a        = r_a;
        n_out_vs   = r_out_vs;
        n_out_nv   = r_out_nv;
        n_out_nw   = r_out_nw;
        n_out_beat = r_out_beat;

        grid_req        = '0;
        grid_req.addr   = r_addr;
        mul_a           = '0;
        mul_b           = '0;

        t_cube  = mul_p + PROD_W'(CUBE_BIAS);
        yp      = 26'(t_cube >>> 24) + 26'(DIV3_OFF);
        c3      = $signed({2'b00, mul_p[48:26]}) - 25'(DIV3_BASE);
        np      = 26'(r_v) - 26'(c3) - 26'(r_w) + 26'(EPS_OFF);
        rn_full = 23'(r_np) - 23'(r_qnp) * 23'(EPS_Q);
        m_op    = {rn_full[10:0], 12'd0} + 23'd901;
        react   = ((25'($signed({1'b0, r_qnp})) - 25'(EPS_Q_BASE)) <<< 12)
                  + 25'({1'b0, mul_p[46:34]});
        sigma   = 20'(rq_p) + 20'(r_wl);
        wt      = sat16(48'(r_w) + 48'(rq_p));

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_col  = cin;
                    n_row  = rin;
                    n_addr = cell_addr(cin, rin);
                    unique case (i_command)
                        CMD_COMPUTE: n_state = ST_RD0;
                        CMD_COMMIT:  n_state = ST_CMT_RD;
                        CMD_ADVANCE: n_step  = r_step + 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_CMT_RD: begin
                n_state = ST_CMT_WR;
            end
            ST_CMT_WR: begin
                grid_req.we_cur = 1'b1;
                grid_req.wv     = grid_rd.nv;
                grid_req.ww     = grid_rd.nw;
                n_state         = ST_IDLE;
            end
            ST_RD0: begin
                // pacing uses step and beat count as they stand before this cell
                n_ip      = pace_on && !((r_step > r_off) || (r_beats >= r_limit));
                n_wl      = n_ip ? r_wl_pace : 16'(WL_Q);
                n_stop_ev = pace_on && (r_beats == r_limit) && !r_stop_rec;
                if (n_stop_ev) begin
                    n_held     = r_step;
                    n_stop_rec = 1'b1;
                end
                n_state = ST_RD1;
            end
            ST_RD1: begin
                n_v           = grid_rd.v;
                n_w           = grid_rd.w;
                grid_req.addr = cell_addr(cp, r_row);
                mul_a         = MUL_A_W'(grid_rd.v);
                mul_b         = MUL_B_W'(grid_rd.v);
                n_state       = ST_RD2;
            end
            ST_RD2: begin
                n_lap         = LAP_W'(grid_rd.v) - (LAP_W'(r_v) <<< 2);
                grid_req.addr = cell_addr(cm, r_row);
                mul_a         = mul_p[MUL_A_W-1:0];
                mul_b         = MUL_B_W'(r_v);
                n_state       = ST_RD3;
            end
            ST_RD3: begin
                n_lap         = r_lap + LAP_W'(grid_rd.v);
                grid_req.addr = cell_addr(r_col, rp);
                mul_a         = MUL_A_W'(yp);
                mul_b         = MUL_B_W'(RECIP3);
                n_state       = ST_RD4;
            end
            ST_RD4: begin
                n_lap         = r_lap + LAP_W'(grid_rd.v);
                grid_req.addr = cell_addr(r_col, rm);
                n_np          = 22'(np);
                mul_a         = MUL_A_W'(np);
                mul_b         = MUL_B_W'(RECIP_EPS_A);
                n_state       = ST_RD5;
            end
            ST_RD5: begin
                n_lap   = r_lap + LAP_W'(grid_rd.v);
                n_qnp   = mul_p[44:33];
                n_sig   = SIG_TABLE[u_cl[13 -: SIG_AW]];
                n_g     = 18'(r_v) + 18'(BETA_Q) - (18'(18'(r_w) + 18'sd1) >>> 1);
                n_state = ST_D1;
            end
            ST_D1: begin
                mul_a   = MUL_A_W'(m_op);
                mul_b   = MUL_B_W'(RECIP_EPS_B);
                n_state = ST_D2;
            end
            ST_D2: begin
                mul_a   = MUL_A_W'(react) + (r_ip ? MUL_A_W'(IPACE_Q) : '0);
                mul_b   = MUL_B_W'(r_dt);
                n_state = ST_D3;
            end
            ST_D3: begin
                n_acc   = 27'(r_v) + 27'(rq_p);
                mul_a   = MUL_A_W'(r_lap);
                mul_b   = MUL_B_W'(r_gain);
                n_state = ST_D4;
            end
            ST_D4: begin
                n_vt    = sat16(48'(r_acc) + 48'(rq_p));
                mul_a   = MUL_A_W'(EPS_Q);
                mul_b   = MUL_B_W'(r_dt);
                n_state = ST_D5;
            end
            ST_D5: begin
                n_a     = 15'(rq_p);
                mul_a   = MUL_A_W'(r_wh) - MUL_A_W'(r_wl);
                mul_b   = MUL_B_W'(r_sig);
                n_state = ST_D6;
            end
            ST_D6: begin
                mul_a   = MUL_A_W'(r_a);
                mul_b   = MUL_B_W'(sigma);
                n_state = ST_D7;
            end
            ST_D7: begin
                mul_a   = MUL_A_W'(rq_p);
                mul_b   = MUL_B_W'(r_g);
                n_state = ST_D8;
            end
            ST_D8: begin
                grid_req.we_nxt = 1'b1;
                grid_req.wv     = r_vt;
                grid_req.ww     = wt;
                n_out_vs        = r_v;
                n_out_nv        = r_vt;
                n_out_nw        = wt;
                // downward threshold crossing at the pacemaker centre
                n_out_beat      = (r_col == cc) && (r_row == cr)
                                  && (r_vt < 16'(THRESH_Q)) && (r_v >= 16'(THRESH_Q));
                if (n_out_beat && (r_beats != 16'hffff)) begin
                    n_beats = r_beats + 1'b1;
                end
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid            = r_valid;
    assign o_video_sample     = r_out_vs;
    assign o_next_potential   = r_out_nv;
    assign o_next_recovery    = r_out_nw;
    assign o_beat_counted     = r_out_beat;
    assign o_pacer_stop_event = r_stop_ev;
    assign o_stop_step        = r_held;

endmodule
